// File: rtl/msq_pkg.sv
package msq_pkg;

  // Field and register widths
  localparam int ALPHA_W       = 8;
  localparam int COLS_W        = 13;
  localparam int ROWS_W        = 9;
  localparam int ORIGIN_W      = 16;
  localparam int POINT_X_W     = 18;
  localparam int POINT_Y_W     = 19;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_TDATA_W   = 40;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_COLS     = 2'd0;
  localparam logic [1:0] REG_ROWS     = 2'd1;
  localparam logic [1:0] REG_ORIGIN_X = 2'd2;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd3;

  localparam logic [COLS_W-1:0] RST_COLS = 13'd16;
  localparam logic [ROWS_W-1:0] RST_ROWS = 9'd16;

  // Parameter defaults
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 256;

  // Square coordinates in a job, sized for the largest parameter values
  localparam int SX_W = 16;
  localparam int SY_W = 12;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [COLS_W-1:0]   cols;
    logic [ROWS_W-1:0]   rows;
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
  } msq_cfg_t;

  // One pixel's work: the square above it (a) and the square below it (b).
  // kase_b is zero when the pixel does not end a column.
  typedef struct packed {
    logic [3:0]      kase_a;
    logic [3:0]      kase_b;
    logic [SX_W-1:0] sx;
    logic [SY_W-1:0] sy;
  } msq_job_t;

  localparam logic [2:0] PT_COUNT [16] = '{
    3'd0, 3'd2, 3'd2, 3'd2, 3'd2, 3'd4, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd4, 3'd2, 3'd2, 3'd2, 3'd2, 3'd0
  };

  // Table points in half-pixel units
  localparam logic [1:0] PT_X [16][4] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0},
    '{2'd0, 2'd1, 2'd0, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd0},
    '{2'd0, 2'd2, 2'd0, 2'd0},
    '{2'd1, 2'd2, 2'd0, 2'd0},
    '{2'd0, 2'd1, 2'd1, 2'd2},
    '{2'd1, 2'd1, 2'd0, 2'd0},
    '{2'd0, 2'd1, 2'd0, 2'd0},
    '{2'd0, 2'd1, 2'd0, 2'd0},
    '{2'd1, 2'd1, 2'd0, 2'd0},
    '{2'd0, 2'd1, 2'd1, 2'd2},
    '{2'd1, 2'd2, 2'd0, 2'd0},
    '{2'd0, 2'd2, 2'd0, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd0},
    '{2'd0, 2'd1, 2'd0, 2'd0},
    '{2'd0, 2'd0, 2'd0, 2'd0}
  };

  localparam logic [1:0] PT_Y [16][4] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0},
    '{2'd1, 2'd2, 2'd0, 2'd0},
    '{2'd1, 2'd2, 2'd0, 2'd0},
    '{2'd1, 2'd1, 2'd0, 2'd0},
    '{2'd0, 2'd1, 2'd0, 2'd0},
    '{2'd1, 2'd0, 2'd2, 2'd1},
    '{2'd0, 2'd2, 2'd0, 2'd0},
    '{2'd1, 2'd0, 2'd0, 2'd0},
    '{2'd1, 2'd0, 2'd0, 2'd0},
    '{2'd0, 2'd2, 2'd0, 2'd0},
    '{2'd1, 2'd0, 2'd2, 2'd1},
    '{2'd0, 2'd1, 2'd0, 2'd0},
    '{2'd1, 2'd1, 2'd0, 2'd0},
    '{2'd1, 2'd2, 2'd0, 2'd0},
    '{2'd1, 2'd2, 2'd0, 2'd0},
    '{2'd0, 2'd0, 2'd0, 2'd0}
  };

endpackage

// File: rtl/marching_squares_outline.sv
// Marching-squares outline tracer for one image cell. Alpha pixels stream in
// on s_* in column-major order (column 0 top to bottom, then column 1, ...),
// followed by one pad column as tall as the cell whose alpha is ignored.
// A pixel is set when its alpha is nonzero. Every 2x2 square yields 0, 2 or 4
// outline points in half-pixel units, offset by the cell origin, with y
// negated; they leave on m_* one word per cycle while m_tready is high,
// m_tlast marking the last point caused by an input pixel. The front accepts
// one pixel per cycle as long as its two-entry job queue has room; the back
// emits one point per cycle while m_tready is high. A pixel owes its points
// (typically 2, at most 6) as one job, a pixel that owes no points pushes no
// job, and the point generator sets the sustained rate. After reset the
// front sweeps all MAX_HEIGHT entries (256 by default) of the column memory
// to zero with s_tready low; configuration writes are taken throughout.
// Program the APB registers only while the block is idle: width in pixels
// at 0x0, height in pixels at 0x4, origin_x at 0x8, origin_y at 0xC.
module marching_squares_outline #(
  parameter int MAX_WIDTH  = msq_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = msq_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  // pixel stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [msq_pkg::IN_TDATA_W-1:0]   s_tdata,   // [7:0] alpha
  // point stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [msq_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [17:0] point_x, [36:18] point_y
  output logic                             m_tlast,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [msq_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [msq_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [msq_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import msq_pkg::*;

  msq_cfg_t             cfg;
  logic                 cfg_wr;
  logic [1:0]           reg_sel;
  logic                 job_push, job_full, job_valid, job_pop;
  msq_job_t             job_in, job_out;
  logic [POINT_X_W-1:0] point_x;
  logic [POINT_Y_W-1:0] point_y;

  // Register file: write on the access phase, zero wait states
  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cols     <= RST_COLS;
      cfg.rows     <= RST_ROWS;
      cfg.origin_x <= '0;
      cfg.origin_y <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_COLS:     cfg.cols     <= pwdata[COLS_W-1:0];
        REG_ROWS:     cfg.rows     <= pwdata[ROWS_W-1:0];
        REG_ORIGIN_X: cfg.origin_x <= pwdata[ORIGIN_W-1:0];
        REG_ORIGIN_Y: cfg.origin_y <= pwdata[ORIGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_COLS:     prdata = CFG_DATA_W'(cfg.cols);
      REG_ROWS:     prdata = CFG_DATA_W'(cfg.rows);
      REG_ORIGIN_X: prdata = CFG_DATA_W'(cfg.origin_x);
      REG_ORIGIN_Y: prdata = CFG_DATA_W'(cfg.origin_y);
      default:      prdata = '0;
    endcase
  end

  // Front: track row and column, look up the left neighbor, classify squares
  msq_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix_valid (s_tvalid),
    .pix_ready (s_tready),
    .alpha     (s_tdata[ALPHA_W-1:0]),
    .job_push  (job_push),
    .job       (job_in),
    .job_full  (job_full)
  );

  // Short queue: let the front run ahead while the back drains points
  msq_queue #(
    .WIDTH ($bits(msq_job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .valid (job_valid),
    .rdata (job_out)
  );

  // Back: expand each job into its table points, one per cycle while m_tready is high
  msq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job       (job_out),
    .job_pop   (job_pop),
    .pt_valid  (m_tvalid),
    .pt_ready  (m_tready),
    .point_x   (point_x),
    .point_y   (point_y),
    .last      (m_tlast)
  );

  assign m_tdata = {{(OUT_TDATA_W - POINT_X_W - POINT_Y_W){1'b0}}, point_y, point_x};

endmodule

// File: rtl/msq_ram.sv
module msq_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/msq_front.sv
module msq_front #(
  parameter int MAX_WIDTH  = msq_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = msq_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  msq_pkg::msq_cfg_t             cfg,
  input  logic                          pix_valid,
  output logic                          pix_ready,
  input  logic [msq_pkg::ALPHA_W-1:0]   alpha,
  output logic                          job_push,
  output msq_pkg::msq_job_t             job,
  input  logic                          job_full
);
  import msq_pkg::*;

  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH + 1);

  logic [RW-1:0] row, row_next, clr_addr;
  logic [CW-1:0] col, col_next;
  logic [CW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic          clearing;
  logic          left_above, cur_above;
  logic          fwd, fwd_bit;
  logic          accept, pix_bit, left, last_row;
  logic          we, wdata;
  logic [RW-1:0] waddr, raddr;
  logic [0:0]    rdata;
  logic [3:0]    kase_a, kase_b;
  logic [2:0]    n_pts;

  always_comb begin
    if (cfg.cols == '0) begin
      w_eff = CW'(1);
    end else if (32'(cfg.cols) > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(cfg.cols);
    end
    if (cfg.rows == '0) begin
      h_eff = HW'(1);
    end else if (32'(cfg.rows) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg.rows);
    end
  end

  assign pix_ready = !clearing && !job_full;
  assign accept    = pix_valid && pix_ready;

  assign left     = fwd ? fwd_bit : rdata[0];
  assign pix_bit  = (col < w_eff) && (alpha != '0);
  assign last_row = (HW'(row) + HW'(1)) >= h_eff;

  assign kase_a = (col != '0 && row != '0) ? {left_above, cur_above, pix_bit, left} : 4'd0;
  assign kase_b = (col != '0 && last_row) ? {left, pix_bit, 2'b00} : 4'd0;
  assign n_pts  = PT_COUNT[kase_a] + PT_COUNT[kase_b];

  assign job.kase_a = kase_a;
  assign job.kase_b = kase_b;
  assign job.sx     = SX_W'(col - CW'(1));
  assign job.sy     = SY_W'(row);
  assign job_push   = accept && (n_pts != 3'd0);

  always_comb begin
    if (last_row) begin
      row_next = '0;
      col_next = (col >= w_eff) ? '0 : col + CW'(1);
    end else begin
      row_next = row + RW'(1);
      col_next = col;
    end
  end

  // Prefetch the stored bit of the row the next pixel lands on
  assign raddr = accept ? row_next : row;
  assign we    = clearing || accept;
  assign waddr = clearing ? clr_addr : row;
  assign wdata = clearing ? 1'b0 : pix_bit;

  msq_ram #(
    .WIDTH (1),
    .DEPTH (MAX_HEIGHT)
  ) u_col_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clr_addr   <= '0;
      row        <= '0;
      col        <= '0;
      left_above <= 1'b0;
      cur_above  <= 1'b0;
      fwd        <= 1'b0;
      fwd_bit    <= 1'b0;
    end else begin
      fwd     <= we && (waddr == raddr);
      fwd_bit <= wdata;
      if (clearing) begin
        clr_addr <= clr_addr + RW'(1);
        if (clr_addr == RW'(MAX_HEIGHT - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        row        <= row_next;
        col        <= col_next;
        left_above <= left;
        cur_above  <= pix_bit;
      end
    end
  end

endmodule

// File: rtl/msq_queue.sv
module msq_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [NW-1:0]    fill;
  logic             do_push, do_pop;

  assign full    = (fill == NW'(DEPTH));
  assign valid   = (fill != '0);
  assign rdata   = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + NW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

// File: rtl/msq_back.sv
module msq_back (
  input  logic                          clk,
  input  logic                          rst,
  input  msq_pkg::msq_cfg_t             cfg,
  input  logic                          job_valid,
  input  msq_pkg::msq_job_t             job,
  output logic                          job_pop,
  output logic                          pt_valid,
  input  logic                          pt_ready,
  output logic [msq_pkg::POINT_X_W-1:0] point_x,
  output logic [msq_pkg::POINT_Y_W-1:0] point_y,
  output logic                          last
);
  import msq_pkg::*;

  logic [2:0]          k;
  logic [2:0]          cnt_a, n_pts;
  logic                is_a, is_last, load;
  logic [1:0]          idx;
  logic [3:0]          kase;
  logic [SY_W-1:0]     sy;
  logic [ORIGIN_W:0]   sum_x, sum_y;
  logic [POINT_X_W-1:0] px, py;

  assign cnt_a   = PT_COUNT[job.kase_a];
  assign n_pts   = cnt_a + PT_COUNT[job.kase_b];
  assign is_a    = k < cnt_a;
  assign idx     = is_a ? k[1:0] : 2'(k - cnt_a);
  assign kase    = is_a ? job.kase_a : job.kase_b;
  assign sy      = is_a ? job.sy - SY_W'(1) : job.sy;
  assign is_last = (k == n_pts - 3'd1);

  assign sum_x = (ORIGIN_W + 1)'(cfg.origin_x) + (ORIGIN_W + 1)'(job.sx);
  assign sum_y = (ORIGIN_W + 1)'(cfg.origin_y) + (ORIGIN_W + 1)'(sy);
  assign px    = {sum_x, 1'b0} + POINT_X_W'(PT_X[kase][idx]);
  assign py    = {sum_y, 1'b0} + POINT_X_W'(PT_Y[kase][idx]);

  // Fill the output register from a waiting job whenever it is empty or being drained
  assign load    = job_valid && (!pt_valid || pt_ready);
  assign job_pop = load && is_last;

  always_ff @(posedge clk) begin
    if (load) begin
      point_x <= px;
      point_y <= POINT_Y_W'(0) - POINT_Y_W'(py);
      last    <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= '0;
      pt_valid <= 1'b0;
    end else begin
      if (load) begin
        pt_valid <= 1'b1;
        k        <= is_last ? 3'd0 : k + 3'd1;
      end else if (pt_ready) begin
        pt_valid <= 1'b0;
      end
    end
  end

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msq_pkg::*;

  // Crossing sides of a square, in half-pixel units:
  // left (0,1), top (1,0), bottom (1,2), right (2,1).
  typedef enum logic [1:0] {SIDE_L, SIDE_T, SIDE_B, SIDE_R} side_t;

  typedef struct packed {
    logic [POINT_X_W-1:0] x;
    logic [POINT_Y_W-1:0] y;
    logic                 last;
  } outline_point_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;     // [7:0] alpha

  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;          // [17:0] point_x, [36:18] point_y
  logic                   m_tlast;

  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr = '0;
  logic [CFG_DATA_W-1:0]  pwdata = '0;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  marching_squares_outline u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops points.
  initial begin
    #3_000_000;
    $display("marching_squares_outline verification failed");
    $finish;
  end

  // Shadow of the register file, updated at the edge of each APB write.
  logic [COLS_W-1:0]   cfg_width    = RST_COLS;
  logic [ROWS_W-1:0]   cfg_height   = RST_ROWS;
  logic [ORIGIN_W-1:0] cfg_origin_x = '0;
  logic [ORIGIN_W-1:0] cfg_origin_y = '0;

  // Tracer state: bits of the previous column, the two samples above the
  // current pixel, and the scan position inside the cell.
  logic        col_bits [DEF_MAX_HEIGHT] = '{default: 1'b0};
  logic        left_above = 1'b0;
  logic        cur_above  = 1'b0;
  int unsigned row_pos = 0;
  int unsigned col_pos = 0;

  logic [ALPHA_W-1:0] pixel_q [$];       // alphas waiting to be driven
  outline_point_t     pending_points [$]; // points owed by the block
  int                 pushed_total   = 0;
  int                 accepted_total = 0;
  int                 mismatches     = 0;
  bit                 stall_en       = 1'b1;

  // Append the crossing points of one square to the owed points.
  function automatic void emit_square(logic [3:0] kase, int unsigned sx, int unsigned sy);
    logic [7:0]     path;
    int             cnt;
    side_t          s;
    int unsigned    dx, dy, px, py;
    outline_point_t p;
    path = '0;
    cnt  = 2;
    // path holds the sides in order, first side in the low bits
    case (kase)
      4'd1, 4'd14: path = {4'b0000, SIDE_B, SIDE_L};
      4'd2, 4'd13: path = {4'b0000, SIDE_B, SIDE_R};
      4'd3, 4'd12: path = {4'b0000, SIDE_R, SIDE_L};
      4'd4, 4'd11: path = {4'b0000, SIDE_R, SIDE_T};
      4'd6, 4'd9:  path = {4'b0000, SIDE_B, SIDE_T};
      4'd7, 4'd8:  path = {4'b0000, SIDE_T, SIDE_L};
      4'd5, 4'd10: begin
        path = {SIDE_R, SIDE_B, SIDE_T, SIDE_L};
        cnt  = 4;
      end
      default: cnt = 0;
    endcase
    for (int i = 0; i < cnt; i++) begin
      s = side_t'(path[2*i +: 2]);
      case (s)
        SIDE_L:  begin dx = 0; dy = 1; end
        SIDE_T:  begin dx = 1; dy = 0; end
        SIDE_B:  begin dx = 1; dy = 2; end
        default: begin dx = 2; dy = 1; end
      endcase
      px     = 2 * (cfg_origin_x + sx) + dx;
      py     = 2 * (cfg_origin_y + sy) + dy;
      p.x    = POINT_X_W'(px);
      p.y    = POINT_Y_W'(32'd0 - py);
      p.last = 1'b0;
      pending_points.push_back(p);
    end
  endfunction

  // Advance the tracer by one accepted pixel and queue the points it owes.
  function automatic void trace_pixel(logic [ALPHA_W-1:0] alpha);
    int unsigned w, h, r, c;
    logic        set_now, left;
    bit          last_row;
    int          first;
    w = cfg_width;
    h = cfg_height;
    if (w == 0) w = 1;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    if (h == 0) h = 1;
    if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
    r = (row_pos >= DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT - 1 : row_pos;
    c = col_pos;

    // pad column samples are empty whatever the alpha
    set_now  = (c < w) && (alpha != 0);
    left     = col_bits[r];
    last_row = (r + 1 >= h);
    first    = pending_points.size();

    if (c >= 1) begin
      if (r >= 1) emit_square({left_above, cur_above, set_now, left}, c - 1, r - 1);
      // bottom row of the column: the square below sees zeros
      if (last_row) emit_square({left, set_now, 2'b00}, c - 1, r);
    end
    if (pending_points.size() > first)
      pending_points[pending_points.size() - 1].last = 1'b1;

    left_above = left;
    cur_above  = set_now;
    col_bits[r] = set_now;

    if (last_row) begin
      row_pos = 0;
      col_pos = (c >= w) ? 0 : ((c + 1) & 32'h1FFF);
    end else begin
      row_pos = r + 1;
    end
  endfunction

  // Pixel driver: hold a word until it is taken, then pull the next one from
  // the queue unless this cycle is an idle one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        trace_pixel(s_tdata);
        accepted_total++;
      end
      if (!s_tvalid || s_tready) begin
        if (pixel_q.size() != 0 && !(stall_en && $urandom_range(99) < 14)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pixel_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Point monitor: compare each taken word with the oldest owed point and
  // stall the output at random.
  always @(posedge clk) begin
    outline_point_t exp_pt;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_points.size() == 0) begin
          $error("unexpected point: point_x %0d point_y %0d last %0b",
                 m_tdata[17:0], $signed(m_tdata[36:18]), m_tlast);
          mismatches++;
        end else begin
          exp_pt = pending_points.pop_front();
          if (m_tdata[17:0] !== exp_pt.x) begin
            $error("point_x: expected %0d, got %0d", exp_pt.x, m_tdata[17:0]);
            mismatches++;
          end
          if (m_tdata[36:18] !== exp_pt.y) begin
            $error("point_y: expected %0d, got %0d",
                   $signed(exp_pt.y), $signed(m_tdata[36:18]));
            mismatches++;
          end
          if (m_tlast !== exp_pt.last) begin
            $error("last: expected %0b, got %0b", exp_pt.last, m_tlast);
            mismatches++;
          end
        end
      end
      m_tready <= !(stall_en && $urandom_range(99) < 14);
    end
  end

  // One APB write: setup cycle, then access until pready; mirror the value
  // into the shadow registers at the edge where the block takes it.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_COLS:     cfg_width    = value[COLS_W-1:0];
      REG_ROWS:     cfg_height   = value[ROWS_W-1:0];
      REG_ORIGIN_X: cfg_origin_x = value[ORIGIN_W-1:0];
      default:      cfg_origin_y = value[ORIGIN_W-1:0];
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold until every queued pixel is taken and every owed point has come,
  // then let the block settle.
  task automatic wait_drained();
    while (accepted_total != pushed_total || pending_points.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Program the geometry with junk above each register's width.
  task automatic set_geometry(input int unsigned w, input int unsigned h,
                              input int unsigned ox, input int unsigned oy);
    wait_drained();
    write_reg(REG_COLS,     ($urandom << COLS_W)   | (w & 32'h1FFF));
    write_reg(REG_ROWS,     ($urandom << ROWS_W)   | (h & 32'h1FF));
    write_reg(REG_ORIGIN_X, ($urandom << ORIGIN_W) | (ox & 32'hFFFF));
    write_reg(REG_ORIGIN_Y, ($urandom << ORIGIN_W) | (oy & 32'hFFFF));
  endtask

  task automatic push_pixel(input logic [ALPHA_W-1:0] alpha);
    pixel_q.push_back(alpha);
    pushed_total++;
  endtask

  task automatic push_random(input int count);
    for (int i = 0; i < count; i++)
      push_pixel(($urandom_range(9) < 4) ? 8'd0 : 8'($urandom_range(255)));
  endtask

  initial begin
    int          total;
    int          phase;
    int unsigned w, h, ox, oy;
    int          count;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: 2x3 cell at the largest origin so point_y wraps, single bits
    // and full bytes of alpha, nonzero alpha in the pad column.
    set_geometry(2, 3, 65535, 65535);
    push_pixel(8'h01); push_pixel(8'h00); push_pixel(8'hFF);
    push_pixel(8'h00); push_pixel(8'h80); push_pixel(8'h7F);
    push_pixel(8'hFF); push_pixel(8'h00); push_pixel(8'h01);

    // Zero geometry behaves as a 1x1 cell.
    set_geometry(0, 0, 0, 0);
    push_pixel(8'h10); push_pixel(8'h20);
    push_pixel(8'h00); push_pixel(8'h40);

    // Checkerboards give the two saddle cases.
    set_geometry(3, 2, 1, 2);
    push_pixel(8'h04); push_pixel(8'h00);
    push_pixel(8'h00); push_pixel(8'h08);
    push_pixel(8'h02); push_pixel(8'h00);
    push_pixel(8'hFF); push_pixel(8'hFF);

    // Random small cells; most are complete, some are cut short so the next
    // geometry starts mid-cell. Each phase waits for the block to drain.
    total = 0;
    phase = 0;
    while (total < 40 || phase < 5) begin
      w = $urandom_range(1, 5);
      h = $urandom_range(1, 6);
      case ($urandom_range(3))
        0:       begin ox = 0;     oy = 65535; end
        1:       begin ox = 65535; oy = 0; end
        default: begin ox = $urandom_range(65535); oy = $urandom_range(65535); end
      endcase
      // a long stretch with both sides always ready
      stall_en <= !(phase >= 1 && phase < 4);
      set_geometry(w, h, ox, oy);
      count = (w + 1) * h;
      if ($urandom_range(4) == 0) count = $urandom_range(1, count);
      push_random(count);
      total += count;
      phase++;
    end
    stall_en <= 1'b1;

    // Extremes: widest cell and out-of-range codes, each cut short, then the
    // top of a cell at the tallest height.
    set_geometry(4096, 1, 65535, 0);
    push_random(8);
    set_geometry(8191, 511, 0, 65535);
    push_random(10);
    set_geometry(1, 256, $urandom_range(65535), $urandom_range(65535));
    push_random(16);

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("marching_squares_outline verification clean");
    end else begin
      $display("marching_squares_outline verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/msq_pkg.sv
rtl/msq_ram.sv
rtl/msq_front.sv
rtl/msq_queue.sv
rtl/msq_back.sv
rtl/marching_squares_outline.sv
tb/tb.sv
